// ===== src/barycentric_coordinates_3d_assert.svh =====
// Assertion macros for the barycentric coordinates block.
// Expects clk_i and rst_ni in the including scope.
`ifndef BARYCENTRIC_COORDINATES_3D_ASSERT_SVH
`define BARYCENTRIC_COORDINATES_3D_ASSERT_SVH

// Check an expression at every clock edge out of reset
`define BCC3_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Check a consequent in the same cycle as its antecedent
`define BCC3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/bcc3_pkg.sv =====
// Shared types, widths and helper functions for the barycentric block.
// No dependencies.
package bcc3_pkg;

  localparam int COORD_W          = 16;
  localparam int DIFF_W           = COORD_W + 1;
  localparam int PROD_W           = 2 * DIFF_W;
  localparam int DOT_W            = PROD_W + 2;
  localparam int HALF_W           = DOT_W / 2;
  localparam int PP_W             = 2 * HALF_W + 1;
  localparam int WIDE_W           = 2 * DOT_W;
  localparam int WEIGHT_W         = 24;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int PRESHIFT         = WEIGHT_W - WEIGHT_FRAC_BITS;
  localparam int EXT_W            = WIDE_W + PRESHIFT;
  localparam int DIV_STEPS        = WEIGHT_W;
  localparam int FIFO_DEPTH       = 4;
  localparam int FIFO_AW          = 2;
  localparam int PIPE_LAT         = 36;

  localparam logic [WEIGHT_W-1:0] W_MAX     = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0] W_NEG_MAG = {1'b1, {(WEIGHT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vec3_t;

  // Gram matrix entries of one item
  typedef struct packed {
    logic signed [DOT_W-1:0] d00;
    logic signed [DOT_W-1:0] d01;
    logic signed [DOT_W-1:0] d11;
    logic signed [DOT_W-1:0] d20;
    logic signed [DOT_W-1:0] d21;
  } dots_t;

  // Partial products of one 36x36 multiply
  typedef struct packed {
    logic signed [PP_W-1:0] hh;
    logic signed [PP_W-1:0] hl;
    logic signed [PP_W-1:0] lh;
    logic signed [PP_W-1:0] ll;
  } pp_t;

  // Divider input: lane 0 is u, 1 is v, 2 is w
  typedef struct packed {
    logic                   degen;
    logic [2:0]             neg;
    logic [WIDE_W-1:0]      den;
    logic [2:0][WIDE_W-1:0] mag;
  } ratio_t;

  function automatic pp_t mul_split(logic signed [DOT_W-1:0] a, logic signed [DOT_W-1:0] b);
    logic signed [PP_W-1:0] ah, bh, al, bl;
    pp_t r;
    ah = PP_W'($signed(a[DOT_W-1:HALF_W]));
    bh = PP_W'($signed(b[DOT_W-1:HALF_W]));
    al = $signed({{(PP_W-HALF_W){1'b0}}, a[HALF_W-1:0]});
    bl = $signed({{(PP_W-HALF_W){1'b0}}, b[HALF_W-1:0]});
    r.hh = ah * bh;
    r.hl = ah * bl;
    r.lh = al * bh;
    r.ll = al * bl;
    return r;
  endfunction

  // One restoring division step: {quotient bit, new remainder}
  function automatic logic [WIDE_W:0] div_step(logic [WIDE_W-1:0] rem, logic nbit,
                                               logic [WIDE_W-1:0] den);
    logic [WIDE_W:0] trial;
    logic [WIDE_W:0] diff;
    trial = {rem, nbit};
    diff  = trial - {1'b0, den};
    if (diff[WIDE_W]) begin
      return {1'b0, trial[WIDE_W-1:0]};
    end
    return {1'b1, diff[WIDE_W-1:0]};
  endfunction

endpackage

// ===== src/barycentric_coordinates_3d.sv =====
// Barycentric coordinates of a 3D point against a triangle, top level.
// Depends on bcc3_pkg, bcc3_front, bcc3_fifo, bcc3_gram, bcc3_div and
// barycentric_coordinates_3d_assert.svh.
//
// Usage: drive point and the three vertices (signed Q8.8) and raise start.
// A word is taken at a clock edge with start high and busy low. busy is high
// during reset and otherwise only if the front-to-back queue is full, which
// does not happen since the back end never stalls: one word per cycle.
// Each result (weights u, v, w in signed Q8.16, truncated toward zero and
// saturated, plus the degenerate flag) shows on the result ports for one
// cycle with done_o high, in the order the starts were taken.
// Pipeline: 3 front stages, 2 in the queue, 5 for determinant and numerators,
// 1 divider entry, 24 divider steps (one quotient bit each) and 1 output.
// The receiver cannot hold results off; none are dropped. Reset clears all
// valid flags and the queue; nothing is left in flight.
`include "barycentric_coordinates_3d_assert.svh"

module barycentric_coordinates_3d import bcc3_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [COORD_W-1:0]  point_x_i,
  input  logic signed [COORD_W-1:0]  point_y_i,
  input  logic signed [COORD_W-1:0]  point_z_i,
  input  logic signed [COORD_W-1:0]  vert_a_x_i,
  input  logic signed [COORD_W-1:0]  vert_a_y_i,
  input  logic signed [COORD_W-1:0]  vert_a_z_i,
  input  logic signed [COORD_W-1:0]  vert_b_x_i,
  input  logic signed [COORD_W-1:0]  vert_b_y_i,
  input  logic signed [COORD_W-1:0]  vert_b_z_i,
  input  logic signed [COORD_W-1:0]  vert_c_x_i,
  input  logic signed [COORD_W-1:0]  vert_c_y_i,
  input  logic signed [COORD_W-1:0]  vert_c_z_i,
  output logic                       done_o,
  output logic signed [WEIGHT_W-1:0] weight_u_o,
  output logic signed [WEIGHT_W-1:0] weight_v_o,
  output logic signed [WEIGHT_W-1:0] weight_w_o,
  output logic                       degenerate_o
);

  logic                accept, live_q;
  logic                fr_valid, q_full, q_valid, gr_valid;
  dots_t               fr_dots, q_dots;
  ratio_t              gr_ratio;
  vec3_t               pt, va, vb, vc;
  logic [WEIGHT_W-1:0] wts [3];
  logic                wts_zero;

  // hold busy through reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else begin
      live_q <= 1'b1;
    end
  end

  assign busy   = q_full || !live_q;
  assign accept = start && !busy;

  assign pt = '{point_x_i, point_y_i, point_z_i};
  assign va = '{vert_a_x_i, vert_a_y_i, vert_a_z_i};
  assign vb = '{vert_b_x_i, vert_b_y_i, vert_b_z_i};
  assign vc = '{vert_c_x_i, vert_c_y_i, vert_c_z_i};

  bcc3_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .p_i     (pt),
    .a_i     (va),
    .b_i     (vb),
    .c_i     (vc),
    .valid_o (fr_valid),
    .dots_o  (fr_dots)
  );

  bcc3_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (fr_valid),
    .wdata_i  (fr_dots),
    .full_o   (q_full),
    .rvalid_o (q_valid),
    .rdata_o  (q_dots)
  );

  bcc3_gram u_gram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .dots_i  (q_dots),
    .valid_o (gr_valid),
    .ratio_o (gr_ratio)
  );

  bcc3_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (gr_valid),
    .ratio_i  (gr_ratio),
    .done_o   (done_o),
    .weight_o (wts),
    .degen_o  (degenerate_o)
  );

  assign weight_u_o = wts[0];
  assign weight_v_o = wts[1];
  assign weight_w_o = wts[2];

  // all three weights zero
  assign wts_zero = (wts[0] == '0) && (wts[1] == '0) && (wts[2] == '0);

  // checks
  `BCC3_ASSERT_ALWAYS(a_no_overflow, !(fr_valid && q_full), "queue overflow")
  `BCC3_ASSERT_ALWAYS(a_latency, done_o == $past(accept, PIPE_LAT), "result timing off")
  `BCC3_ASSERT_IMP(a_degen_zero, done_o && degenerate_o, wts_zero, "degenerate weights not zero")

endmodule

// ===== src/bcc3_front.sv =====
// Front end: edge vectors, products and the five dot products, three stages.
// Depends on bcc3_pkg.
module bcc3_front import bcc3_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  vec3_t p_i,
  input  vec3_t a_i,
  input  vec3_t b_i,
  input  vec3_t c_i,
  output logic  valid_o,
  output dots_t dots_o
);

  logic signed [COORD_W-1:0] p [3], a [3], b [3], c [3];
  logic signed [DIFF_W-1:0]  e0_q [3], e1_q [3], qv_q [3];
  logic signed [PROD_W-1:0]  p00_q [3], p01_q [3], p11_q [3], p20_q [3], p21_q [3];
  logic [2:0]                vld_q;
  dots_t                     dots_q;

  // unpack coordinates
  always_comb begin
    p = '{p_i.x, p_i.y, p_i.z};
    a = '{a_i.x, a_i.y, a_i.z};
    b = '{b_i.x, b_i.y, b_i.z};
    c = '{c_i.x, c_i.y, c_i.z};
  end

  // valid shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // stage 1 differences, stage 2 products, stage 3 sums
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      e0_q[k]  <= DIFF_W'(b[k]) - DIFF_W'(a[k]);
      e1_q[k]  <= DIFF_W'(c[k]) - DIFF_W'(a[k]);
      qv_q[k]  <= DIFF_W'(p[k]) - DIFF_W'(a[k]);
      p00_q[k] <= PROD_W'(e0_q[k]) * PROD_W'(e0_q[k]);
      p01_q[k] <= PROD_W'(e0_q[k]) * PROD_W'(e1_q[k]);
      p11_q[k] <= PROD_W'(e1_q[k]) * PROD_W'(e1_q[k]);
      p20_q[k] <= PROD_W'(qv_q[k]) * PROD_W'(e0_q[k]);
      p21_q[k] <= PROD_W'(qv_q[k]) * PROD_W'(e1_q[k]);
    end
    dots_q.d00 <= DOT_W'(p00_q[0]) + DOT_W'(p00_q[1]) + DOT_W'(p00_q[2]);
    dots_q.d01 <= DOT_W'(p01_q[0]) + DOT_W'(p01_q[1]) + DOT_W'(p01_q[2]);
    dots_q.d11 <= DOT_W'(p11_q[0]) + DOT_W'(p11_q[1]) + DOT_W'(p11_q[2]);
    dots_q.d20 <= DOT_W'(p20_q[0]) + DOT_W'(p20_q[1]) + DOT_W'(p20_q[2]);
    dots_q.d21 <= DOT_W'(p21_q[0]) + DOT_W'(p21_q[1]) + DOT_W'(p21_q[2]);
  end

  assign valid_o = vld_q[2];
  assign dots_o  = dots_q;

endmodule

// ===== src/bcc3_fifo.sv =====
// Short queue of dot-product words between front and back, registered read.
// Depends on bcc3_pkg.
module bcc3_fifo import bcc3_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  dots_t wdata_i,
  output logic  full_o,
  output logic  rvalid_o,
  output dots_t rdata_o
);

  dots_t               mem_q [FIFO_DEPTH];
  dots_t               rdata_q;
  logic [FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]    cnt_q, cnt_d;
  logic                pop, rvalid_q;

  // back end always takes a word when one is queued
  assign pop    = (cnt_q != '0);
  assign full_o = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      rvalid_q <= pop;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // storage and read register
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
    if (pop) begin
      rdata_q <= mem_q[rd_ptr_q];
    end
  end

  assign rvalid_o = rvalid_q;
  assign rdata_o  = rdata_q;

endmodule

// ===== src/bcc3_gram.sv =====
// Back end part one: determinant and Cramer numerators, signs and magnitudes.
// Five stages; 36x36 products split into 18-bit partials. Depends on bcc3_pkg.
module bcc3_gram import bcc3_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  dots_t  dots_i,
  output logic   valid_o,
  output ratio_t ratio_o
);

  pp_t                     pp_q [6];
  logic signed [WIDE_W-1:0] prod_q [6];
  logic signed [WIDE_W-1:0] den_q, nv_q, nw_q;
  logic signed [WIDE_W-1:0] den4_q, nu4_q, nv4_q, nw4_q;
  logic signed [WIDE_W-1:0] num [3];
  ratio_t                  ratio_q;
  logic [4:0]              vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  assign num = '{nu4_q, nv4_q, nw4_q};

  always_ff @(posedge clk_i) begin
    // partial products
    pp_q[0] <= mul_split(dots_i.d00, dots_i.d11);
    pp_q[1] <= mul_split(dots_i.d01, dots_i.d01);
    pp_q[2] <= mul_split(dots_i.d11, dots_i.d20);
    pp_q[3] <= mul_split(dots_i.d01, dots_i.d21);
    pp_q[4] <= mul_split(dots_i.d00, dots_i.d21);
    pp_q[5] <= mul_split(dots_i.d01, dots_i.d20);
    // recombine
    for (int k = 0; k < 6; k++) begin
      prod_q[k] <= (WIDE_W'(pp_q[k].hh) <<< (2*HALF_W))
                 + ((WIDE_W'(pp_q[k].hl) + WIDE_W'(pp_q[k].lh)) <<< HALF_W)
                 + WIDE_W'(pp_q[k].ll);
    end
    // determinant and numerators
    den_q  <= prod_q[0] - prod_q[1];
    nv_q   <= prod_q[2] - prod_q[3];
    nw_q   <= prod_q[4] - prod_q[5];
    den4_q <= den_q;
    nv4_q  <= nv_q;
    nw4_q  <= nw_q;
    nu4_q  <= den_q - nv_q - nw_q;
    // sign and magnitude; nonpositive determinant is degenerate
    ratio_q.degen <= den4_q[WIDE_W-1] || (den4_q == '0);
    ratio_q.den   <= den4_q;
    for (int l = 0; l < 3; l++) begin
      ratio_q.neg[l] <= num[l][WIDE_W-1];
      ratio_q.mag[l] <= num[l][WIDE_W-1] ? WIDE_W'(-num[l]) : num[l];
    end
  end

  assign valid_o = vld_q[4];
  assign ratio_o = ratio_q;

endmodule

// ===== src/bcc3_div.sv =====
// Back end part two: three-lane pipelined restoring divider, one quotient
// bit per stage, then saturation to Q8.16. Depends on bcc3_pkg.
module bcc3_div import bcc3_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  ratio_t              ratio_i,
  output logic                done_o,
  output logic [WEIGHT_W-1:0] weight_o [3],
  output logic                degen_o
);

  logic [WIDE_W-1:0]   rem_q  [3][DIV_STEPS+1];
  logic [WEIGHT_W-1:0] sh_q   [3][DIV_STEPS+1];
  logic                over_q [3][DIV_STEPS+1];
  logic                neg_q  [3][DIV_STEPS+1];
  logic [WIDE_W-1:0]   den_q  [DIV_STEPS+1];
  logic                dgn_q  [DIV_STEPS+1];
  logic [DIV_STEPS:0]  vld_q;
  logic [WEIGHT_W-1:0] w_q [3];
  logic                degen_q, done_q;

  function automatic logic [WEIGHT_W-1:0] fmt(logic [WEIGHT_W-1:0] q, logic neg,
                                              logic over, logic degen);
    logic [WEIGHT_W-1:0] m;
    if (degen) begin
      return '0;
    end
    if (neg) begin
      m = (over || q > W_NEG_MAG) ? W_NEG_MAG : q;
      return WEIGHT_W'(0) - m;
    end
    return (over || q > W_MAX) ? W_MAX : q;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[DIV_STEPS-1:0], valid_i};
      done_q <= vld_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin : p_div
    logic [WIDE_W:0] st;
    // entry: quotient of at least 2^WEIGHT_W is flagged as overflow
    den_q[0] <= ratio_i.den;
    dgn_q[0] <= ratio_i.degen;
    for (int l = 0; l < 3; l++) begin
      rem_q[l][0]  <= WIDE_W'(ratio_i.mag[l] >> PRESHIFT);
      sh_q[l][0]   <= WEIGHT_W'(ratio_i.mag[l] << WEIGHT_FRAC_BITS);
      over_q[l][0] <= EXT_W'(ratio_i.mag[l]) >= (EXT_W'(ratio_i.den) << PRESHIFT);
      neg_q[l][0]  <= ratio_i.neg[l];
    end
    // one quotient bit per stage; numerator bits shift out as quotient shifts in
    for (int s = 0; s < DIV_STEPS; s++) begin
      den_q[s+1] <= den_q[s];
      dgn_q[s+1] <= dgn_q[s];
      for (int l = 0; l < 3; l++) begin
        st = div_step(rem_q[l][s], sh_q[l][s][WEIGHT_W-1], den_q[s]);
        rem_q[l][s+1]  <= st[WIDE_W-1:0];
        sh_q[l][s+1]   <= {sh_q[l][s][WEIGHT_W-2:0], st[WIDE_W]};
        over_q[l][s+1] <= over_q[l][s];
        neg_q[l][s+1]  <= neg_q[l][s];
      end
    end
    // output word
    for (int l = 0; l < 3; l++) begin
      w_q[l] <= fmt(sh_q[l][DIV_STEPS], neg_q[l][DIV_STEPS], over_q[l][DIV_STEPS],
                    dgn_q[DIV_STEPS]);
    end
    degen_q <= dgn_q[DIV_STEPS];
  end

  assign done_o   = done_q;
  assign weight_o = w_q;
  assign degen_o  = degen_q;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for barycentric_coordinates_3d: a directed table, then random words.
// Expected weights come from the directed table or an exact-integer predictor in this file; uses bcc3_pkg.
module testbench;
  import bcc3_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] p [3];
    logic signed [COORD_W-1:0] a [3];
    logic signed [COORD_W-1:0] b [3];
    logic signed [COORD_W-1:0] c [3];
  } query_t;

  typedef struct {
    logic signed [WEIGHT_W-1:0] u;
    logic signed [WEIGHT_W-1:0] v;
    logic signed [WEIGHT_W-1:0] w;
    logic                       degen;
  } weights_t;

  typedef struct {
    query_t   q;
    bit       typed;
    weights_t exp;
  } row_t;

  localparam logic signed [WEIGHT_W-1:0] ONE  = 24'sd65536;
  localparam logic signed [WEIGHT_W-1:0] WMAX = 24'sd8388607;
  localparam logic signed [WEIGHT_W-1:0] WMIN = -24'sd8388608;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_W-1:0] px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz;
  logic done_o, degenerate_o;
  logic signed [WEIGHT_W-1:0] weight_u_o, weight_v_o, weight_w_o;

  weights_t pending_weights [$];
  int errors = 0;
  row_t dir_rows [$];

  always #5 clk_i = ~clk_i;

  barycentric_coordinates_3d dut (
    .clk_i, .rst_ni, .start, .busy,
    .point_x_i(px), .point_y_i(py), .point_z_i(pz),
    .vert_a_x_i(ax), .vert_a_y_i(ay), .vert_a_z_i(az),
    .vert_b_x_i(bx), .vert_b_y_i(by), .vert_b_z_i(bz),
    .vert_c_x_i(cx), .vert_c_y_i(cy), .vert_c_z_i(cz),
    .done_o, .weight_u_o, .weight_v_o, .weight_w_o, .degenerate_o
  );

  // Truncate num/den to Q.16 and clamp to 24 bits
  function automatic logic signed [WEIGHT_W-1:0] clamp_ratio(logic signed [127:0] num,
                                                              logic signed [127:0] den);
    logic signed [127:0] qt;
    qt = (num * 128'sd65536) / den;
    if (qt > 128'sd8388607) return WMAX;
    if (qt < -128'sd8388608) return WMIN;
    return qt[WEIGHT_W-1:0];
  endfunction

  // Exact Cramer solution over the Gram matrix
  function automatic weights_t solve_weights(query_t q);
    longint e0 [3], e1 [3], dq [3];
    longint d00, d01, d11, d20, d21;
    logic signed [127:0] w00, w01, w11, w20, w21, den, nv, nw;
    weights_t r;
    d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
    for (int k = 0; k < 3; k++) begin
      e0[k] = longint'(q.b[k]) - longint'(q.a[k]);
      e1[k] = longint'(q.c[k]) - longint'(q.a[k]);
      dq[k] = longint'(q.p[k]) - longint'(q.a[k]);
      d00 += e0[k] * e0[k];
      d01 += e0[k] * e1[k];
      d11 += e1[k] * e1[k];
      d20 += dq[k] * e0[k];
      d21 += dq[k] * e1[k];
    end
    w00 = 128'(d00); w01 = 128'(d01); w11 = 128'(d11);
    w20 = 128'(d20); w21 = 128'(d21);
    den = w00 * w11 - w01 * w01;
    if (den <= 0) begin
      r = '{u: '0, v: '0, w: '0, degen: 1'b1};
      return r;
    end
    nv = w11 * w20 - w01 * w21;
    nw = w00 * w21 - w01 * w20;
    r.u = clamp_ratio(den - nv - nw, den);
    r.v = clamp_ratio(nv, den);
    r.w = clamp_ratio(nw, den);
    r.degen = 1'b0;
    return r;
  endfunction

  function automatic query_t mk_query(int p0, int p1, int p2, int a0, int a1, int a2,
                                      int b0, int b1, int b2, int c0, int c1, int c2);
    query_t q;
    q.p = '{COORD_W'(p0), COORD_W'(p1), COORD_W'(p2)};
    q.a = '{COORD_W'(a0), COORD_W'(a1), COORD_W'(a2)};
    q.b = '{COORD_W'(b0), COORD_W'(b1), COORD_W'(b2)};
    q.c = '{COORD_W'(c0), COORD_W'(c1), COORD_W'(c2)};
    return q;
  endfunction

  function automatic void add_row(query_t q, bit typed, weights_t e);
    row_t r;
    r.q = q; r.typed = typed; r.exp = e;
    dir_rows.push_back(r);
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    weights_t e;
    if (rst_ni && done_o) begin
      if (pending_weights.size() == 0) begin
        $display("mismatch: result word with nothing expected");
        errors++;
      end else begin
        e = pending_weights.pop_front();
        if (weight_u_o !== e.u) report("weight_u", int'(weight_u_o), int'(e.u));
        if (weight_v_o !== e.v) report("weight_v", int'(weight_v_o), int'(e.v));
        if (weight_w_o !== e.w) report("weight_w", int'(weight_w_o), int'(e.w));
        if (degenerate_o !== e.degen)
          report("degenerate", int'(degenerate_o), int'(e.degen));
      end
    end
  end

  // Drive one word, hold until taken, then idle for the drawn gap
  task automatic send(query_t q, bit typed, weights_t e, int gap);
    @(negedge clk_i);
    {px, py, pz} = {q.p[0], q.p[1], q.p[2]};
    {ax, ay, az} = {q.a[0], q.a[1], q.a[2]};
    {bx, by, bz} = {q.b[0], q.b[1], q.b[2]};
    {cx, cy, cz} = {q.c[0], q.c[1], q.c[2]};
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    pending_weights.push_back(typed ? e : solve_weights(q));
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  function automatic int rnd16();
    return int'($signed(16'($urandom)));
  endfunction

  function automatic int near(int base, int span);
    int v;
    v = base + $urandom_range(0, 2 * span) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  // Mostly small triangles at random places, some collinear ones, some raw noise
  function automatic query_t rand_query();
    query_t q;
    int kind, span, k;
    kind = $urandom_range(0, 9);
    span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(1, 600);
    for (int i = 0; i < 3; i++) begin
      q.a[i] = COORD_W'(rnd16());
      q.b[i] = COORD_W'(near(int'(q.a[i]), span));
      q.c[i] = COORD_W'(near(int'(q.a[i]), span));
      q.p[i] = ($urandom_range(0, 4) == 0) ? COORD_W'(rnd16())
                                             : COORD_W'(near(int'(q.a[i]), 2 * span));
    end
    if (kind < 2) begin
      k = $urandom_range(0, 4) - 2;
      for (int i = 0; i < 3; i++) q.c[i] = 16'(q.a[i] + k * (q.b[i] - q.a[i]));
    end else if (kind == 2) begin
      for (int i = 0; i < 3; i++) begin
        q.a[i] = COORD_W'(rnd16()); q.b[i] = COORD_W'(rnd16());
        q.c[i] = COORD_W'(rnd16()); q.p[i] = COORD_W'(rnd16());
      end
    end
    return q;
  endfunction

  initial begin
    weights_t dg, none, at_a, at_b, at_c, far_x;
    int gap_mode;
    dg    = '{u: '0, v: '0, w: '0, degen: 1'b1};
    none  = dg;
    at_a  = '{u: ONE, v: '0, w: '0, degen: 1'b0};
    at_b  = '{u: '0, v: ONE, w: '0, degen: 1'b0};
    at_c  = '{u: '0, v: '0, w: ONE, degen: 1'b0};
    far_x = '{u: WMIN, v: WMAX, w: '0, degen: 1'b0};
    {px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz} = '0;

    // Directed words
    add_row(mk_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, dg);
    add_row(mk_query(5, 6, 7, 1, 1, 1, 1, 1, 1, 1, 1, 1), 1, dg);
    add_row(mk_query(0, 0, 0, 0, 0, 0, 1, 1, 1, 2, 2, 2), 1, dg);
    add_row(mk_query(-32768, -32768, -32768, 32767, 32767, 32767,
                     -32768, -32768, -32768, 32767, 32767, 32767), 1, dg);
    add_row(mk_query(0, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0), 1, at_a);
    add_row(mk_query(256, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0), 1, at_b);
    add_row(mk_query(0, 256, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0), 1, at_c);
    add_row(mk_query(32767, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0), 1, far_x);
    add_row(mk_query(-32768, -32768, 32767, 0, 0, 0, 1, 0, 0, 0, 1, 0), 0, none);
    add_row(mk_query(32767, 32767, 32767, -32768, -32768, -32768,
                     32767, -32768, -32768, -32768, 32767, -32768), 0, none);
    add_row(mk_query(-32768, 32767, -32768, 32767, -32768, 32767,
                     -32768, 32767, 32767, 32767, 32767, -32768), 0, none);
    add_row(mk_query(100, 100, 50, 0, 0, 0, 300, 0, 0, 0, 300, 0), 0, none);
    add_row(mk_query(-1, -1, -1, 32767, -32768, 0, 32767, 32767, 0, -32768, 0, 32767), 0, none);
    add_row(mk_query(3, 0, 0, 0, 0, 0, 1, 1, 0, 1, 1, 1), 0, none);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i])
      send(dir_rows[i].q, dir_rows[i].typed, dir_rows[i].exp, $urandom_range(0, 12));

    // Random words; alternate stretches of back-to-back and idled traffic
    gap_mode = 0;
    for (int n = 0; n < 400; n++) begin
      if (n % 40 == 0) gap_mode = $urandom_range(0, 2);
      send(rand_query(), 0, none, (gap_mode == 0) ? 0 : $urandom_range(0, 12));
    end
    @(negedge clk_i);
    start = 1'b0;

    for (int t = 0; t < 2000 && pending_weights.size() != 0; t++) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0 && pending_weights.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #500000;
    $display("tb: failure");
    $finish;
  end

endmodule
